// ----- sv/kpvt_pkg.sv -----
// ----------------------------------------------------------------------------
// kpvt_pkg
// Types and fixed constants shared by the position/velocity tracker modules.
// ----------------------------------------------------------------------------
package kpvt_pkg;

  // States of the serial multiply-divide unit.
  typedef enum logic [2:0] {
    MD_IDLE,
    MD_MUL,
    MD_ROUND,
    MD_CHECK,
    MD_DIV,
    MD_FIN
  } md_state_e;

  // States of the filter sequencer.
  typedef enum logic [1:0] {
    SQ_IDLE,
    SQ_START,
    SQ_WAIT,
    SQ_OUT
  } seq_state_e;

  // One entry per multiply-divide operation of an update, in issue order.
  typedef enum logic [3:0] {
    OP_VEL,
    OP_PP_PV,
    OP_PP_VV,
    OP_PP_A,
    OP_PV_VV,
    OP_PV_A,
    OP_VV_A,
    OP_DX,
    OP_DV,
    OP_DVV,
    OP_DPV,
    OP_DPP
  } op_e;

  // Status of the multiply-divide unit as seen by the sequencer.
  typedef struct packed {
    logic busy;
    logic done;
  } md_status_t;

  // Divisors of the constant-gain prediction terms (dt = 0.01 s).
  localparam logic [63:0] DivPosStep   = 64'd100;
  localparam logic [63:0] DivCrossPp   = 64'd50;
  localparam logic [63:0] DivVelPp     = 64'd10000;
  localparam logic [63:0] DivAccelPp   = 64'd400000000;
  localparam logic [63:0] DivVelPv     = 64'd100;
  localparam logic [63:0] DivAccelPv   = 64'd2000000;
  localparam logic [63:0] DivAccelVv   = 64'd10000;

  localparam logic [31:0] AccelReset   = 32'h0100_0000;
  localparam logic [63:0] SatMax64     = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] SatMin64     = 64'h8000_0000_0000_0000;

endpackage

// ----- sv/kpvt_muldiv.sv -----
// ----------------------------------------------------------------------------
// kpvt_muldiv
// Bit-serial round(a*b/d): shift-add multiply, round, restoring divide.
// ----------------------------------------------------------------------------
module kpvt_muldiv (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [63:0]              op_a_i,
  input  logic [63:0]              op_b_i,
  input  logic [63:0]              divisor_i,
  output kpvt_pkg::md_status_t     status_o,
  output logic [63:0]              result_o
);

  kpvt_pkg::md_state_e state_q, state_d;
  logic [63:0] mcand_q, mcand_d;
  logic [63:0] hi_q, hi_d;
  logic [63:0] lo_q, lo_d;
  logic [63:0] div_q, div_d;
  logic        neg_q, neg_d;
  logic [5:0]  cnt_q, cnt_d;

  logic [64:0] mul_sum;
  logic [64:0] rnd_sum;
  logic [64:0] rem_sh;
  logic [64:0] rem_diff;
  logic        rem_ge;

  function automatic logic [63:0] mag(input logic [63:0] x);
    return x[63] ? (~x + 64'd1) : x;
  endfunction

  function automatic logic [63:0] from_mag(input logic [63:0] q, input logic neg);
    if (neg) begin
      return q[63] ? kpvt_pkg::SatMin64 : (~q + 64'd1);
    end
    return q[63] ? kpvt_pkg::SatMax64 : q;
  endfunction

  assign mul_sum  = {1'b0, hi_q} + (lo_q[0] ? {1'b0, mcand_q} : 65'd0);
  assign rnd_sum  = {1'b0, lo_q} + {2'b00, div_q[63:1]};
  assign rem_sh   = {hi_q, lo_q[63]};
  assign rem_ge   = rem_sh >= {1'b0, div_q};
  assign rem_diff = rem_sh - {1'b0, div_q};

  always_comb begin
    state_d = state_q;
    mcand_d = mcand_q;
    hi_d    = hi_q;
    lo_d    = lo_q;
    div_d   = div_q;
    neg_d   = neg_q;
    cnt_d   = cnt_q;
    case (state_q)
      kpvt_pkg::MD_IDLE: begin
        if (start_i) begin
          mcand_d = mag(op_a_i);
          lo_d    = mag(op_b_i);
          hi_d    = '0;
          div_d   = divisor_i;
          neg_d   = op_a_i[63] ^ op_b_i[63];
          cnt_d   = '0;
          state_d = kpvt_pkg::MD_MUL;
        end
      end
      kpvt_pkg::MD_MUL: begin
        hi_d  = mul_sum[64:1];
        lo_d  = {mul_sum[0], lo_q[63:1]};
        cnt_d = cnt_q + 6'd1;
        if (&cnt_q) begin
          state_d = kpvt_pkg::MD_ROUND;
        end
      end
      kpvt_pkg::MD_ROUND: begin
        lo_d    = rnd_sum[63:0];
        hi_d    = hi_q + {63'd0, rnd_sum[64]};
        state_d = kpvt_pkg::MD_CHECK;
      end
      kpvt_pkg::MD_CHECK: begin
        // A quotient wider than 64 bits saturates.
        if (hi_q >= div_q) begin
          lo_d    = '1;
          state_d = kpvt_pkg::MD_FIN;
        end else begin
          cnt_d   = '0;
          state_d = kpvt_pkg::MD_DIV;
        end
      end
      kpvt_pkg::MD_DIV: begin
        hi_d  = rem_ge ? rem_diff[63:0] : rem_sh[63:0];
        lo_d  = {lo_q[62:0], rem_ge};
        cnt_d = cnt_q + 6'd1;
        if (&cnt_q) begin
          state_d = kpvt_pkg::MD_FIN;
        end
      end
      kpvt_pkg::MD_FIN: begin
        state_d = kpvt_pkg::MD_IDLE;
      end
      default: begin
        state_d = kpvt_pkg::MD_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= kpvt_pkg::MD_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mcand_q <= mcand_d;
    hi_q    <= hi_d;
    lo_q    <= lo_d;
    div_q   <= div_d;
    neg_q   <= neg_d;
  end

  assign status_o.busy = state_q != kpvt_pkg::MD_IDLE;
  assign status_o.done = state_q == kpvt_pkg::MD_FIN;
  assign result_o      = from_mag(lo_q, neg_q);

endmodule

// ----- sv/kalman_position_velocity_tracker.sv -----
// ----------------------------------------------------------------------------
// kalman_position_velocity_tracker
// Two-state constant-velocity Kalman filter for one measured position.
// ----------------------------------------------------------------------------
// Usage: one transaction on the slave stream carries one item. tuser selects
// the kind: 0 is a measurement update, 1 loads the start position and
// velocity given in tdata. Every item yields exactly one transaction on the
// master stream with both estimates and the three covariance terms.
// The acceleration noise variance is written through the cfg channel, which
// is always ready; it should only change while no item is in flight.
// A reset item goes from the idle state straight to the output state, which
// loads the output register. An update runs twelve multiply-divide
// operations in order on one shared bit-serial unit, each made of 64
// multiply steps, a rounding step, a saturation check, 64 divide steps and
// a finishing step; an operation whose quotient saturates skips its divide
// steps. That unit sets the throughput; only one item is in progress at a time.
// The result sits in an output register, so a new item is accepted while the
// previous result still waits; a stalled receiver holds the finished item in
// the sequencer until the output register frees up.
// Reset clears the estimates, sets the position variance to 1e10, the cross
// term to zero, the velocity variance and the register to 1.0.
// ----------------------------------------------------------------------------
module kalman_position_velocity_tracker #(
  parameter int unsigned COV_FRAC_BITS = 28
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  // Configuration write channel.
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [31:0]  cfg_wdata_i,     // accel_variance
  // Slave stream.
  input  logic         s_tvalid_i,
  output logic         s_tready_o,
  input  logic [63:0]  s_tdata_i,       // [31:0] measurement, [63:32] start_velocity
  input  logic         s_tuser_i,       // mode
  // Master stream.
  output logic         m_tvalid_o,
  input  logic         m_tready_i,
  output logic [255:0] m_tdata_o        // [31:0] position_estimate,
                                        // [63:32] velocity_estimate,
                                        // [126:64] position_variance,
                                        // [190:127] cross_covariance,
                                        // [253:191] velocity_variance, rest zero
);

  // Initial position variance: 1e10, saturated when it does not fit.
  localparam logic [63:0] BigVar =
      (64'd10000000000 > (kpvt_pkg::SatMax64 >> COV_FRAC_BITS)) ?
      kpvt_pkg::SatMax64 : (64'd10000000000 << COV_FRAC_BITS);
  // Measurement variance 0.2, rounded to nearest.
  localparam logic [63:0] MeasVar = ((64'd1 << COV_FRAC_BITS) + 64'd2) / 64'd5;
  // Velocity variance after reset: the register's reset value of 1.0.
  localparam logic [63:0] VvReset = 64'd1 << COV_FRAC_BITS;

  kpvt_pkg::seq_state_e state_q, state_d;
  kpvt_pkg::op_e        op_q, op_d;

  logic [31:0] accel_q, accel_d;
  logic [31:0] pos_q, pos_d;
  logic [31:0] vel_q, vel_d;
  logic [63:0] pp_q, pp_d;
  logic [63:0] pv_q, pv_d;
  logic [63:0] vv_q, vv_d;
  logic [31:0] z_q, z_d;
  logic [32:0] y_q, y_d;

  logic         m_valid_q, m_valid_d;
  logic [31:0]  out_pos_q, out_pos_d;
  logic [31:0]  out_vel_q, out_vel_d;
  logic [62:0]  out_pp_q, out_pp_d;
  logic [63:0]  out_pv_q, out_pv_d;
  logic [62:0]  out_vv_q, out_vv_d;

  logic [63:0] accel_scaled;
  logic [32:0] y_now;
  logic        md_start;
  logic [63:0] md_a, md_b, md_div;
  logic [63:0] md_res;
  kpvt_pkg::md_status_t md_status;

  // The register is Q8.24; bring it to the covariance format.
  if (COV_FRAC_BITS >= 24) begin : g_accel_up
    assign accel_scaled = {32'd0, accel_q} << (COV_FRAC_BITS - 24);
  end else begin : g_accel_dn
    logic [32:0] accel_rnd;
    assign accel_rnd    = {1'b0, accel_q} + (33'd1 << (23 - COV_FRAC_BITS));
    assign accel_scaled = {31'd0, accel_rnd} >> (24 - COV_FRAC_BITS);
  end

  // Innovation, taken against the predicted position.
  assign y_now = {z_q[31], z_q} - {pos_q[31], pos_q};

  function automatic logic [63:0] sat_add(input logic [63:0] x, input logic [63:0] y);
    logic [64:0] s;
    s = {x[63], x} + {y[63], y};
    if (s[64] != s[63]) begin
      return s[64] ? kpvt_pkg::SatMin64 : kpvt_pkg::SatMax64;
    end
    return s[63:0];
  endfunction

  function automatic logic [63:0] sat_sub(input logic [63:0] x, input logic [63:0] y);
    logic [64:0] s;
    s = {x[63], x} - {y[63], y};
    if (s[64] != s[63]) begin
      return s[64] ? kpvt_pkg::SatMin64 : kpvt_pkg::SatMax64;
    end
    return s[63:0];
  endfunction

  function automatic logic [63:0] clamp0(input logic [63:0] x);
    return x[63] ? 64'd0 : x;
  endfunction

  // Exact sum of a 32-bit estimate and a 64-bit step, saturated to 32 bits.
  function automatic logic [31:0] sat32_add(input logic [31:0] p, input logic [63:0] r);
    logic [64:0] s;
    s = {{33{p[31]}}, p} + {r[63], r};
    if (!(&s[64:31]) && |s[64:31]) begin
      return s[64] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end
    return s[31:0];
  endfunction

  // Operand selection for the shared multiply-divide unit. Constant-gain
  // terms use a multiplier of one, so rounding matches the ratio terms.
  always_comb begin
    md_a   = '0;
    md_b   = 64'd1;
    md_div = 64'd1;
    case (op_q)
      kpvt_pkg::OP_VEL: begin
        md_a   = {{32{vel_q[31]}}, vel_q};
        md_div = kpvt_pkg::DivPosStep;
      end
      kpvt_pkg::OP_PP_PV: begin
        md_a   = pv_q;
        md_div = kpvt_pkg::DivCrossPp;
      end
      kpvt_pkg::OP_PP_VV: begin
        md_a   = vv_q;
        md_div = kpvt_pkg::DivVelPp;
      end
      kpvt_pkg::OP_PP_A: begin
        md_a   = accel_scaled;
        md_div = kpvt_pkg::DivAccelPp;
      end
      kpvt_pkg::OP_PV_VV: begin
        md_a   = vv_q;
        md_div = kpvt_pkg::DivVelPv;
      end
      kpvt_pkg::OP_PV_A: begin
        md_a   = accel_scaled;
        md_div = kpvt_pkg::DivAccelPv;
      end
      kpvt_pkg::OP_VV_A: begin
        md_a   = accel_scaled;
        md_div = kpvt_pkg::DivAccelVv;
      end
      kpvt_pkg::OP_DX: begin
        md_a   = {{31{y_now[32]}}, y_now};
        md_b   = pp_q;
        md_div = pp_q + MeasVar;
      end
      kpvt_pkg::OP_DV: begin
        md_a   = {{31{y_q[32]}}, y_q};
        md_b   = pv_q;
        md_div = pp_q + MeasVar;
      end
      kpvt_pkg::OP_DVV: begin
        md_a   = pv_q;
        md_b   = pv_q;
        md_div = pp_q + MeasVar;
      end
      kpvt_pkg::OP_DPV: begin
        md_a   = pv_q;
        md_b   = pp_q;
        md_div = pp_q + MeasVar;
      end
      kpvt_pkg::OP_DPP: begin
        md_a   = pp_q;
        md_b   = pp_q;
        md_div = pp_q + MeasVar;
      end
      default: begin
        md_a = '0;
      end
    endcase
  end

  kpvt_muldiv u_muldiv (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (md_start),
    .op_a_i    (md_a),
    .op_b_i    (md_b),
    .divisor_i (md_div),
    .status_o  (md_status),
    .result_o  (md_res)
  );

  // Sequencer. The state terms are updated in place: each operation reads
  // only values that no earlier operation of the same update has replaced
  // in a way it must not see.
  always_comb begin
    state_d   = state_q;
    op_d      = op_q;
    accel_d   = accel_q;
    pos_d     = pos_q;
    vel_d     = vel_q;
    pp_d      = pp_q;
    pv_d      = pv_q;
    vv_d      = vv_q;
    z_d       = z_q;
    y_d       = y_q;
    m_valid_d = m_valid_q;
    out_pos_d = out_pos_q;
    out_vel_d = out_vel_q;
    out_pp_d  = out_pp_q;
    out_pv_d  = out_pv_q;
    out_vv_d  = out_vv_q;
    md_start  = 1'b0;

    if (cfg_valid_i) begin
      accel_d = cfg_wdata_i;
    end
    if (m_valid_q && m_tready_i) begin
      m_valid_d = 1'b0;
    end

    case (state_q)
      kpvt_pkg::SQ_IDLE: begin
        if (s_tvalid_i) begin
          if (s_tuser_i) begin
            pos_d   = s_tdata_i[31:0];
            vel_d   = s_tdata_i[63:32];
            pp_d    = BigVar;
            pv_d    = '0;
            vv_d    = accel_scaled;
            state_d = kpvt_pkg::SQ_OUT;
          end else begin
            z_d     = s_tdata_i[31:0];
            op_d    = kpvt_pkg::OP_VEL;
            state_d = kpvt_pkg::SQ_START;
          end
        end
      end
      kpvt_pkg::SQ_START: begin
        md_start = 1'b1;
        if (op_q == kpvt_pkg::OP_DX) begin
          y_d = y_now;
        end
        state_d = kpvt_pkg::SQ_WAIT;
      end
      kpvt_pkg::SQ_WAIT: begin
        if (md_status.done) begin
          case (op_q)
            kpvt_pkg::OP_VEL:   pos_d = sat32_add(pos_q, md_res);
            kpvt_pkg::OP_PP_PV: pp_d  = sat_add(pp_q, md_res);
            kpvt_pkg::OP_PP_VV: pp_d  = sat_add(pp_q, md_res);
            kpvt_pkg::OP_PP_A:  pp_d  = clamp0(sat_add(pp_q, md_res));
            kpvt_pkg::OP_PV_VV: pv_d  = sat_add(pv_q, md_res);
            kpvt_pkg::OP_PV_A:  pv_d  = sat_add(pv_q, md_res);
            kpvt_pkg::OP_VV_A:  vv_d  = clamp0(sat_add(vv_q, md_res));
            kpvt_pkg::OP_DX:    pos_d = sat32_add(pos_q, md_res);
            kpvt_pkg::OP_DV:    vel_d = sat32_add(vel_q, md_res);
            kpvt_pkg::OP_DVV:   vv_d  = clamp0(sat_sub(vv_q, md_res));
            kpvt_pkg::OP_DPV:   pv_d  = sat_sub(pv_q, md_res);
            kpvt_pkg::OP_DPP:   pp_d  = clamp0(sat_sub(pp_q, md_res));
            default:            pos_d = pos_q;
          endcase
          if (op_q == kpvt_pkg::OP_DPP) begin
            state_d = kpvt_pkg::SQ_OUT;
          end else begin
            op_d    = kpvt_pkg::op_e'(4'(op_q) + 4'd1);
            state_d = kpvt_pkg::SQ_START;
          end
        end
      end
      kpvt_pkg::SQ_OUT: begin
        if (!m_valid_q || m_tready_i) begin
          out_pos_d = pos_q;
          out_vel_d = vel_q;
          out_pp_d  = pp_q[62:0];
          out_pv_d  = pv_q;
          out_vv_d  = vv_q[62:0];
          m_valid_d = 1'b1;
          state_d   = kpvt_pkg::SQ_IDLE;
        end
      end
      default: begin
        state_d = kpvt_pkg::SQ_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= kpvt_pkg::SQ_IDLE;
      op_q      <= kpvt_pkg::OP_VEL;
      accel_q   <= kpvt_pkg::AccelReset;
      pos_q     <= '0;
      vel_q     <= '0;
      pp_q      <= BigVar;
      pv_q      <= '0;
      vv_q      <= VvReset;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      op_q      <= op_d;
      accel_q   <= accel_d;
      pos_q     <= pos_d;
      vel_q     <= vel_d;
      pp_q      <= pp_d;
      pv_q      <= pv_d;
      vv_q      <= vv_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    z_q       <= z_d;
    y_q       <= y_d;
    out_pos_q <= out_pos_d;
    out_vel_q <= out_vel_d;
    out_pp_q  <= out_pp_d;
    out_pv_q  <= out_pv_d;
    out_vv_q  <= out_vv_d;
  end

  assign cfg_ready_o = 1'b1;
  assign s_tready_o  = state_q == kpvt_pkg::SQ_IDLE;
  assign m_tvalid_o  = m_valid_q;
  assign m_tdata_o   = {2'b00, out_vv_q, out_pv_q, out_pp_q, out_vel_q, out_pos_q};

  // The shared unit is never busy while a new item can be taken.
  a_idle_unit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_tready_o |-> !md_status.busy)
    else $error("multiply-divide unit busy while the sequencer is idle");

  // A finished operation is only reported while the sequencer waits for it.
  a_done_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    md_status.done |-> (state_q == kpvt_pkg::SQ_WAIT))
    else $error("operation finished outside the wait state");

  // Variances are never negative between items. The position variance may
  // pass through a negative value while its prediction terms are summed.
  a_var_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == kpvt_pkg::SQ_IDLE) |-> (!pp_q[63] && !vv_q[63]))
    else $error("negative variance in state");

  // A reset item clears the cross term.
  a_reset_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_tvalid_i && s_tready_o && s_tuser_i) |=> (pv_q == 64'd0))
    else $error("cross term not cleared by a reset item");

endmodule

// ----- tb/sv/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Checks the position/velocity Kalman tracker against a cycle-free predictor
// of its fixed-point arithmetic, using random stream stalls and config phases.
// ----------------------------------------------------------------------------
module tb;

  localparam int unsigned CovFrac  = 28;
  localparam int unsigned Limit    = 20000;
  localparam logic        ModeUpd  = 1'b0;
  localparam logic        ModeLoad = 1'b1;

  typedef struct packed {
    logic [62:0] pvv;
    logic [63:0] ppv;
    logic [62:0] ppp;
    logic [31:0] vel;
    logic [31:0] pos;
  } estimate_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         cfg_valid_i = 1'b0;
  logic         cfg_ready_o;
  logic [31:0]  cfg_wdata_i = '0;
  logic         s_tvalid_i = 1'b0;
  logic         s_tready_o;
  logic [63:0]  s_tdata_i = '0;
  logic         s_tuser_i = 1'b0;
  logic         m_tvalid_o;
  logic         m_tready_i = 1'b0;
  logic [255:0] m_tdata_o;

  kalman_position_velocity_tracker #(.COV_FRAC_BITS(CovFrac)) dut (.*);

  always #10 clk_i = ~clk_i;

  // Tracker state as the predictor sees it.
  logic [31:0] accel_reg;
  logic signed [31:0] trk_pos, trk_vel;
  logic signed [63:0] trk_pp, trk_pv, trk_vv;
  estimate_t   expected_q[$];
  int          mismatches = 0;
  int          idle_cycles = 0;
  bit          quiet = 0;      // no random stalls
  int          hold_off = 0;   // long receiver stall, in cycles

  // ---------------------------------------------------------------- predictor
  function automatic logic signed [63:0] sat_add(logic signed [63:0] a,
                                                 logic signed [63:0] b);
    logic signed [64:0] s;
    s = 65'(a) + 65'(b);
    if (s > 65'sh0_7FFF_FFFF_FFFF_FFFF) return kpvt_pkg::SatMax64;
    if (s < -65'sh0_8000_0000_0000_0000) return kpvt_pkg::SatMin64;
    return s[63:0];
  endfunction

  function automatic logic signed [63:0] sat_sub(logic signed [63:0] a,
                                                 logic signed [63:0] b);
    logic signed [64:0] s;
    s = 65'(a) - 65'(b);
    if (s > 65'sh0_7FFF_FFFF_FFFF_FFFF) return kpvt_pkg::SatMax64;
    if (s < -65'sh0_8000_0000_0000_0000) return kpvt_pkg::SatMin64;
    return s[63:0];
  endfunction

  function automatic logic signed [63:0] sat32(logic signed [63:0] v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic logic signed [63:0] nonneg(logic signed [63:0] v);
    return v < 0 ? 64'sd0 : v;
  endfunction

  // round(a*b/d), ties away from zero, saturated to the signed 64-bit range.
  function automatic logic signed [63:0] scaled_ratio(logic signed [63:0] a,
                                                      logic signed [63:0] b,
                                                      logic [63:0] d);
    logic [63:0]  ma, mb;
    logic [128:0] q;
    bit           neg;
    ma  = a[63] ? -a : a;
    mb  = b[63] ? -b : b;
    neg = a[63] != b[63];
    q   = ({1'b0, ma * {64'd0, mb}} + d / 2) / d;
    if (neg) return q >= 129'h8000_0000_0000_0000 ? kpvt_pkg::SatMin64 : -q[63:0];
    return q > 129'h7FFF_FFFF_FFFF_FFFF ? kpvt_pkg::SatMax64 : q[63:0];
  endfunction

  function automatic logic signed [63:0] accel_cov();
    return 64'(accel_reg) << (CovFrac - 24);
  endfunction

  function automatic void load_tracker(logic [31:0] p, logic [31:0] v);
    trk_pos = p;
    trk_vel = v;
    trk_pp  = 64'd10000000000 << CovFrac;
    trk_pv  = 0;
    trk_vv  = accel_cov();
  endfunction

  function automatic void track_item(logic mode, logic [31:0] z, logic [31:0] v);
    logic signed [63:0] a, pp, pv, vv, pos, y;
    logic [63:0]        s;
    estimate_t          e;
    if (mode == ModeLoad) begin
      load_tracker(z, v);
    end else begin
      a   = accel_cov();
      pp  = trk_pp;
      pv  = trk_pv;
      vv  = trk_vv;
      pos = sat32(64'(trk_pos) + scaled_ratio(64'(trk_vel), 1, kpvt_pkg::DivPosStep));
      pp  = sat_add(pp, scaled_ratio(pv, 1, kpvt_pkg::DivCrossPp));
      pp  = sat_add(pp, scaled_ratio(vv, 1, kpvt_pkg::DivVelPp));
      pp  = nonneg(sat_add(pp, scaled_ratio(a, 1, kpvt_pkg::DivAccelPp)));
      pv  = sat_add(pv, scaled_ratio(vv, 1, kpvt_pkg::DivVelPv));
      pv  = sat_add(pv, scaled_ratio(a, 1, kpvt_pkg::DivAccelPv));
      vv  = nonneg(sat_add(vv, scaled_ratio(a, 1, kpvt_pkg::DivAccelVv)));
      s   = pp + ((64'd1 << CovFrac) + 2) / 5;
      y   = 64'(signed'(z)) - pos;
      trk_pos = 32'(sat32(sat_add(pos, scaled_ratio(y, pp, s))));
      trk_vel = 32'(sat32(sat_add(64'(trk_vel), scaled_ratio(y, pv, s))));
      trk_vv  = nonneg(sat_sub(vv, scaled_ratio(pv, pv, s)));
      trk_pv  = sat_sub(pv, scaled_ratio(pv, pp, s));
      trk_pp  = nonneg(sat_sub(pp, scaled_ratio(pp, pp, s)));
    end
    e.pos = trk_pos;
    e.vel = trk_vel;
    e.ppp = trk_pp[62:0];
    e.ppv = trk_pv;
    e.pvv = trk_vv[62:0];
    expected_q.push_back(e);
  endfunction

  // ------------------------------------------------------------------ drivers
  task automatic send_item(logic mode, logic [31:0] z, logic [31:0] v);
    @(negedge clk_i);
    if (!quiet && $urandom_range(0, 3) == 0) repeat ($urandom_range(1, 3)) @(negedge clk_i);
    s_tvalid_i <= 1'b1;
    s_tuser_i  <= mode;
    s_tdata_i  <= {v, z};
    do @(posedge clk_i); while (!s_tready_o);
    track_item(mode, z, v);
    @(negedge clk_i);
    s_tvalid_i <= 1'b0;
  endtask

  task automatic drain();
    while (expected_q.size() != 0) @(negedge clk_i);
    repeat (10) @(negedge clk_i);
  endtask

  task automatic write_accel(logic [31:0] val);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_wdata_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    accel_reg = val;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 4))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'(signed'($urandom_range(0, 400000)) - 200000);
      default: return $urandom();
    endcase
  endfunction

  // Receiver with random stall bursts and an optional long hold-off.
  always @(negedge clk_i) begin
    if (hold_off > 0) begin
      hold_off   <= hold_off - 1;
      m_tready_i <= 1'b0;
    end else if (!quiet && $urandom_range(0, 3) == 0) begin
      m_tready_i <= 1'b0;
      repeat ($urandom_range(0, 2)) @(negedge clk_i);
    end else begin
      m_tready_i <= 1'b1;
    end
  end

  // Result checker.
  always @(posedge clk_i) begin
    estimate_t got, want;
    if (m_tvalid_o && m_tready_i) begin
      got = m_tdata_o[253:0];
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        mismatches++;
      end else begin
        want = expected_q.pop_front();
        if (got !== want) begin
          $display("%0t: expected %h actual %h", $time, want, got);
          mismatches++;
        end
      end
    end
  end

  // Watchdog on cycles without any transaction.
  always @(posedge clk_i) begin
    if ((s_tvalid_i && s_tready_o) || (m_tvalid_o && m_tready_i) || hold_off > 0)
      idle_cycles = 0;
    else if (++idle_cycles >= Limit) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // -------------------------------------------------------------------- tests
  task automatic test_directed();
    send_item(ModeUpd, 32'h0001_0000, 0);
    send_item(ModeUpd, 32'h7FFF_FFFF, 0);
    send_item(ModeUpd, 32'h8000_0000, 0);
    send_item(ModeLoad, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_item(ModeUpd, 32'h7FFF_FFFF, 0);
    send_item(ModeLoad, 32'h8000_0000, 32'h8000_0000);
    send_item(ModeUpd, 32'h8000_0000, 32'hFFFF_FFFF);
    send_item(ModeUpd, 32'h7FFF_FFFF, 0);
    send_item(ModeLoad, 0, 32'h0005_0000);
    for (int i = 0; i < 8; i++) send_item(ModeUpd, 32'(i) << 12, 0);
  endtask

  task automatic test_random(int n);
    for (int i = 0; i < n; i++)
      if ($urandom_range(0, 19) == 0) send_item(ModeLoad, rand_word(), rand_word());
      else send_item(ModeUpd, rand_word(), rand_word());
  endtask

  // Receiver holds off while the sender keeps going, filling the output path.
  task automatic test_backpressure();
    hold_off = 4000;
    for (int i = 0; i < 4; i++) send_item(ModeUpd, $urandom(), 0);
  endtask

  task automatic test_accel_settings();
    write_accel(32'hFFFF_FFFF);
    send_item(ModeLoad, 0, 0);
    test_random(60);
    write_accel(32'h0000_0000);
    send_item(ModeLoad, 32'h1234_5678, 32'hFEDC_BA98);
    test_random(60);
    write_accel($urandom());
    test_random(60);
  endtask

  initial begin
    accel_reg = kpvt_pkg::AccelReset;
    load_tracker(0, 0);
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_backpressure();
    test_random(200);
    test_accel_settings();
    write_accel(kpvt_pkg::AccelReset);
    quiet = 1;
    test_random(180);
    drain();
    repeat (20) @(negedge clk_i);
    if (mismatches == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end
endmodule

// ----- filelist.f -----
sv/kpvt_pkg.sv
sv/kpvt_muldiv.sv
sv/kalman_position_velocity_tracker.sv
tb/sv/tb.sv
